@@ src/qfp_pkg.sv @@
// ----------------------------------------------------------------------------
// qfp_pkg
// Types and constants shared by the QPACK field line parser.
// ----------------------------------------------------------------------------
package qfp_pkg;

  typedef enum logic [7:0] {
    PH_FIRST    = 8'b0000_0001,
    PH_IDX_INT  = 8'b0000_0010,
    PH_NAME_INT = 8'b0000_0100,
    PH_NAME_SKP = 8'b0000_1000,
    PH_VHDR     = 8'b0001_0000,
    PH_VAL_INT  = 8'b0010_0000,
    PH_VAL_SKP  = 8'b0100_0000,
    PH_DRAIN    = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_DONE,
    EV_ERR
  } event_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_PROTO = 2'd2;

  localparam logic [2:0] KIND_IDX_STATIC  = 3'd0;
  localparam logic [2:0] KIND_IDX_DYN     = 3'd1;
  localparam logic [2:0] KIND_NREF_STATIC = 3'd2;
  localparam logic [2:0] KIND_NREF_DYN    = 3'd3;
  localparam logic [2:0] KIND_LIT_NAME    = 3'd4;
  localparam logic [2:0] KIND_PB_IDX      = 3'd5;
  localparam logic [2:0] KIND_PB_NREF     = 3'd6;

  localparam logic [6:0] PMAX_3 = 7'h07;
  localparam logic [6:0] PMAX_4 = 7'h0F;
  localparam logic [6:0] PMAX_6 = 7'h3F;
  localparam logic [6:0] PMAX_7 = 7'h7F;

  localparam logic [5:0] SHIFT_LIMIT = 6'd62;
  localparam logic [5:0] SHIFT_SAT   = 6'd63;

  typedef struct packed {
    logic [61:0] accum;
    logic [5:0]  shift;
    logic        ovf;
    logic        more;
  } int_step_t;

endpackage

@@ src/qfp_int_step.sv @@
// ----------------------------------------------------------------------------
// qfp_int_step
// One continuation byte of a prefixed integer: 7-bit chunk add with
// 62-bit overflow check and saturating shift count.
// ----------------------------------------------------------------------------
module qfp_int_step
  import qfp_pkg::*;
(
  input  logic [61:0] accum,
  input  logic [5:0]  shift,
  input  logic [7:0]  data,
  output int_step_t   res
);

  logic [6:0]  chunk;
  logic [68:0] addend;
  logic [68:0] sum;
  logic        fits;
  logic [6:0]  shift_sum;

  assign chunk     = data[6:0];
  assign addend    = {62'd0, chunk} << shift;
  assign sum       = {7'd0, accum} + addend;
  assign fits      = (shift < SHIFT_LIMIT) && (sum[68:62] == 7'd0);
  assign shift_sum = {1'b0, shift} + 7'd7;

  always_comb begin
    res.accum = fits ? sum[61:0] : accum;
    res.ovf   = !fits && (chunk != 7'd0);
    res.shift = (shift_sum > {1'b0, SHIFT_SAT}) ? SHIFT_SAT : shift_sum[5:0];
    res.more  = data[7];
  end

endmodule

@@ src/qpack_field_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// qpack_field_line_parser_core
// Parses QPACK field line representations one byte a beat and reports one
// descriptor per finished, truncated or failed line.
// ----------------------------------------------------------------------------
//  channel | signals                        | beat
//  --------+--------------------------------+---------------------------------
//  in      | in_valid / in_stall            | data_byte, section_end
//  out     | out_valid / out_stall          | line descriptor (11 fields)
//
// One byte per cycle sustained while the result channel does not stall; a
// taken byte goes to the input register, and its result beat is then written
// from there into the result register.
// The input register drains only when the result register is free or moving.
// Synchronous reset clears valids and parser state; no clearing pass.
// ----------------------------------------------------------------------------
module qpack_field_line_parser_core
  import qfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        section_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  line_kind,
  output logic        n_bit,
  output logic [61:0] table_index,
  output logic        name_coded,
  output logic [61:0] name_size,
  output logic [63:0] name_start,
  output logic        value_coded,
  output logic [61:0] value_size,
  output logic [63:0] value_start,
  output logic [63:0] line_bytes
);

  // input register
  logic        in_vld;
  logic [7:0]  in_byte;
  logic        in_end;

  // parser state
  phase_t      phase;
  logic [2:0]  kind_reg;
  logic [2:0]  flag_bits;
  logic [61:0] int_accum;
  logic [5:0]  shift_count;
  logic [61:0] index_reg;
  logic [61:0] name_len_reg;
  logic [61:0] value_len_reg;
  logic [61:0] skip_left;
  logic [63:0] byte_count;
  logic [63:0] name_off_reg;
  logic [63:0] value_off_reg;

  phase_t      phase_next;
  logic [2:0]  kind_next;
  logic [2:0]  flag_next;
  logic [61:0] accum_next;
  logic [5:0]  shift_next;
  logic [61:0] index_next;
  logic [61:0] name_len_next;
  logic [61:0] value_len_next;
  logic [61:0] skip_next;
  logic [63:0] byte_count_next;
  logic [63:0] name_off_next;
  logic [63:0] value_off_next;

  logic        proceed;
  logic        accept;
  event_t      ev;
  logic        emit;
  logic [1:0]  res_status;
  logic        start;
  phase_t      int_phase;
  logic [6:0]  pv;
  logic [6:0]  pmax;
  logic        int_done;
  logic [61:0] int_val;
  logic [63:0] count_base;
  int_step_t   istep;

  assign proceed  = in_vld && (!out_valid || !out_stall);
  assign in_stall = in_vld && !proceed;
  assign accept   = in_valid && !in_stall;

  qfp_int_step u_int (
    .accum (int_accum),
    .shift (shift_count),
    .data  (in_byte),
    .res   (istep)
  );

  assign count_base = (phase == PH_FIRST) ? 64'd0 : byte_count;

  always_comb begin
    phase_next      = phase;
    kind_next       = kind_reg;
    flag_next       = flag_bits;
    accum_next      = int_accum;
    shift_next      = shift_count;
    index_next      = index_reg;
    name_len_next   = name_len_reg;
    value_len_next  = value_len_reg;
    skip_next       = skip_left;
    name_off_next   = name_off_reg;
    value_off_next  = value_off_reg;
    byte_count_next = (&count_base) ? count_base : count_base + 64'd1;
    ev              = EV_NONE;
    start           = 1'b0;
    int_phase       = PH_IDX_INT;
    pv              = 7'd0;
    pmax            = PMAX_7;
    int_done        = 1'b0;
    int_val         = 62'd0;

    case (phase)
      PH_FIRST: begin
        flag_next      = 3'd0;
        index_next     = 62'd0;
        name_len_next  = 62'd0;
        value_len_next = 62'd0;
        name_off_next  = 64'd0;
        value_off_next = 64'd0;
        skip_next      = 62'd0;
        start          = 1'b1;
        if (in_byte[7]) begin
          kind_next = in_byte[6] ? KIND_IDX_STATIC : KIND_IDX_DYN;
          pv        = {1'b0, in_byte[5:0]};
          pmax      = PMAX_6;
        end else if (in_byte[6]) begin
          kind_next    = in_byte[4] ? KIND_NREF_STATIC : KIND_NREF_DYN;
          flag_next[0] = in_byte[5];
          pv           = {3'd0, in_byte[3:0]};
          pmax         = PMAX_4;
        end else if (in_byte[5]) begin
          kind_next    = KIND_LIT_NAME;
          flag_next[0] = in_byte[4];
          flag_next[1] = in_byte[3];
          int_phase    = PH_NAME_INT;
          pv           = {4'd0, in_byte[2:0]};
          pmax         = PMAX_3;
        end else if (in_byte[4]) begin
          kind_next = KIND_PB_IDX;
          pv        = {3'd0, in_byte[3:0]};
          pmax      = PMAX_4;
        end else begin
          kind_next    = KIND_PB_NREF;
          flag_next[0] = in_byte[3];
          pv           = {4'd0, in_byte[2:0]};
          pmax         = PMAX_3;
        end
      end
      PH_IDX_INT, PH_NAME_INT, PH_VAL_INT: begin
        int_phase = phase;
        if (istep.ovf) begin
          ev = EV_ERR;
        end else begin
          accum_next = istep.accum;
          shift_next = istep.shift;
          if (!istep.more) begin
            int_done = 1'b1;
            int_val  = istep.accum;
          end
        end
      end
      PH_NAME_SKP: begin
        skip_next = skip_left - 62'd1;
        if (skip_left == 62'd1) begin
          phase_next = PH_VHDR;
        end
      end
      PH_VHDR: begin
        flag_next[2] = flag_bits[2] | in_byte[7];
        start        = 1'b1;
        int_phase    = PH_VAL_INT;
        pv           = in_byte[6:0];
        pmax         = PMAX_7;
      end
      PH_VAL_SKP: begin
        skip_next = skip_left - 62'd1;
        if (skip_left == 62'd1) begin
          ev = EV_DONE;
        end
      end
      PH_DRAIN: begin
        byte_count_next = byte_count;
        if (in_end) begin
          phase_next = PH_FIRST;
        end
      end
      default: begin
        phase_next = PH_FIRST;
      end
    endcase

    if (start) begin
      phase_next = int_phase;
      if (pv < pmax) begin
        int_done = 1'b1;
        int_val  = {55'd0, pv};
      end else begin
        accum_next = {55'd0, pmax};
        shift_next = 6'd0;
      end
    end

    if (int_done) begin
      case (int_phase)
        PH_IDX_INT: begin
          index_next = int_val;
          if (kind_next == KIND_NREF_STATIC || kind_next == KIND_NREF_DYN ||
              kind_next == KIND_PB_NREF) begin
            phase_next = PH_VHDR;
          end else begin
            ev = EV_DONE;
          end
        end
        PH_NAME_INT: begin
          name_len_next = int_val;
          name_off_next = byte_count_next;
          if (int_val == 62'd0) begin
            phase_next = PH_VHDR;
          end else begin
            skip_next  = int_val;
            phase_next = PH_NAME_SKP;
          end
        end
        default: begin
          value_len_next = int_val;
          value_off_next = byte_count_next;
          if (int_val == 62'd0) begin
            ev = EV_DONE;
          end else begin
            skip_next  = int_val;
            phase_next = PH_VAL_SKP;
          end
        end
      endcase
    end

    emit       = 1'b0;
    res_status = ST_OK;
    if (ev == EV_DONE) begin
      emit       = 1'b1;
      phase_next = PH_FIRST;
    end else if (ev == EV_ERR) begin
      emit       = 1'b1;
      res_status = ST_PROTO;
      phase_next = in_end ? PH_FIRST : PH_DRAIN;
    end else if (in_end && phase != PH_DRAIN) begin
      emit       = 1'b1;
      res_status = ST_TRUNC;
      phase_next = PH_FIRST;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (proceed) begin
      in_vld <= 1'b0;
    end
    if (accept) begin
      in_byte <= data_byte;
      in_end  <= section_end;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      kind_reg      <= 3'd0;
      flag_bits     <= 3'd0;
      int_accum     <= 62'd0;
      shift_count   <= 6'd0;
      index_reg     <= 62'd0;
      name_len_reg  <= 62'd0;
      value_len_reg <= 62'd0;
      skip_left     <= 62'd0;
      byte_count    <= 64'd0;
      name_off_reg  <= 64'd0;
      value_off_reg <= 64'd0;
    end else if (proceed) begin
      phase         <= phase_next;
      kind_reg      <= kind_next;
      flag_bits     <= flag_next;
      int_accum     <= accum_next;
      shift_count   <= shift_next;
      index_reg     <= index_next;
      name_len_reg  <= name_len_next;
      value_len_reg <= value_len_next;
      skip_left     <= skip_next;
      byte_count    <= byte_count_next;
      name_off_reg  <= name_off_next;
      value_off_reg <= value_off_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (proceed && emit) begin
      status        <= res_status;
      line_kind     <= kind_next;
      line_bytes    <= byte_count_next;
      n_bit         <= 1'b0;
      table_index   <= 62'd0;
      name_coded    <= 1'b0;
      name_size     <= 62'd0;
      name_start    <= 64'd0;
      value_coded   <= 1'b0;
      value_size    <= 62'd0;
      value_start   <= 64'd0;
      if (res_status == ST_OK) begin
        n_bit <= flag_next[0];
        if (kind_next != KIND_LIT_NAME) begin
          table_index <= index_next;
        end else begin
          name_coded <= flag_next[1];
          name_size  <= name_len_next;
          name_start <= name_off_next;
        end
        if (kind_next == KIND_NREF_STATIC || kind_next == KIND_NREF_DYN ||
            kind_next == KIND_LIT_NAME || kind_next == KIND_PB_NREF) begin
          value_coded <= flag_next[2];
          value_size  <= value_len_next;
          value_start <= value_off_next;
        end
      end
    end
  end

endmodule

@@ src/qfp_checker.sv @@
// ----------------------------------------------------------------------------
// qfp_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module qfp_checker
  import qfp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [2:0]  line_kind,
  input logic        n_bit,
  input logic [61:0] table_index,
  input logic        name_coded,
  input logic [61:0] name_size,
  input logic [63:0] name_start,
  input logic        value_coded,
  input logic [61:0] value_size,
  input logic [63:0] value_start,
  input logic [63:0] line_bytes
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(line_bytes))
    else $error("result beat changed while stalled");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_PROTO && line_kind <= KIND_PB_NREF && line_bytes != 64'd0)
    else $error("result beat carries an undefined code or empty line");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      table_index == 62'd0 && name_size == 62'd0 && value_size == 62'd0 &&
      !n_bit && !name_coded && !value_coded)
    else $error("error beat carries descriptor fields");

  a_name_only_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_kind != KIND_LIT_NAME |->
      name_size == 62'd0 && name_start == 64'd0 && !name_coded)
    else $error("name fields set on a line without a literal name");

  a_offsets: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && line_kind == KIND_LIT_NAME |->
      name_start < value_start && value_start <= line_bytes)
    else $error("literal name offsets out of order");

endmodule

bind qpack_field_line_parser_core qfp_checker u_qfp_checker (.*);

@@ test/tb_qpack_field_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// tb_qpack_field_line_parser_core
// Drives the QPACK field line parser with encoded field sections one byte a
// beat. The sections are built from random field lines of all seven kinds,
// plus cut-off lines, over-limit integers, padded integers and noise. A
// tracker class keeps its own copy of the parser state, predicts a line
// descriptor for each finished, truncated or failed line and compares every output beat with it.
// ----------------------------------------------------------------------------
module tb_qpack_field_line_parser_core;
  import qfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [63:0] WIDE_MAX    = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic        never_idx;
    logic [61:0] tbl_idx;
    logic        name_h;
    logic [61:0] name_len;
    logic [63:0] name_off;
    logic        val_h;
    logic [61:0] val_len;
    logic [63:0] val_off;
    logic [63:0] nbytes;
  } line_desc_t;

  class field_line_tracker;
    localparam logic [63:0] LIMIT62 = 64'h3FFF_FFFF_FFFF_FFFF;

    phase_t      ph;
    logic [2:0]  kind;
    logic [2:0]  flags;
    logic [63:0] accum;
    int unsigned shamt;
    logic [61:0] idx;
    logic [61:0] nlen;
    logic [61:0] vlen;
    logic [63:0] left;
    logic [63:0] nbytes;
    logic [63:0] noff;
    logic [63:0] voff;
    line_desc_t  lines_due[$];
    int unsigned bad;
    int unsigned shown;

    function new();
      ph = PH_FIRST;
      kind = '0;
      flags = '0;
      accum = '0;
      shamt = 0;
      idx = '0;
      nlen = '0;
      vlen = '0;
      left = '0;
      nbytes = '0;
      noff = '0;
      voff = '0;
      bad = 0;
      shown = 0;
    endfunction

    function event_t close_int(logic [63:0] v);
      if (ph == PH_IDX_INT) begin
        idx = v[61:0];
        if (kind == KIND_NREF_STATIC || kind == KIND_NREF_DYN || kind == KIND_PB_NREF) begin
          ph = PH_VHDR;
          return EV_NONE;
        end
        return EV_DONE;
      end
      if (ph == PH_NAME_INT) begin
        nlen = v[61:0];
        noff = nbytes;
        if (nlen == 0) begin
          ph = PH_VHDR;
        end else begin
          left = {2'b00, nlen};
          ph = PH_NAME_SKP;
        end
        return EV_NONE;
      end
      vlen = v[61:0];
      voff = nbytes;
      if (vlen == 0) return EV_DONE;
      left = {2'b00, vlen};
      ph = PH_VAL_SKP;
      return EV_NONE;
    endfunction

    function event_t open_int(phase_t p, logic [6:0] pv, logic [6:0] pmax);
      ph = p;
      if (pv < pmax) return close_int({57'd0, pv});
      accum = {57'd0, pmax};
      shamt = 0;
      return EV_NONE;
    endfunction

    function event_t more_int(logic [7:0] b);
      logic [63:0] chunk;
      logic [63:0] room;
      chunk = {57'd0, b[6:0]};
      room = LIMIT62 - accum;
      if (shamt < 62 && chunk <= (room >> shamt)) begin
        accum = accum + (chunk << shamt);
      end else if (chunk != 0) begin
        return EV_ERR;
      end
      shamt = (shamt + 7 > 63) ? 63 : shamt + 7;
      if (b[7]) return EV_NONE;
      return close_int(accum);
    endfunction

    function event_t first_byte(logic [7:0] b);
      flags = '0;
      idx = '0;
      nlen = '0;
      vlen = '0;
      noff = '0;
      voff = '0;
      left = '0;
      if (b[7]) begin
        kind = b[6] ? KIND_IDX_STATIC : KIND_IDX_DYN;
        return open_int(PH_IDX_INT, {1'b0, b[5:0]}, PMAX_6);
      end
      if (b[6]) begin
        kind = b[4] ? KIND_NREF_STATIC : KIND_NREF_DYN;
        flags[0] = b[5];
        return open_int(PH_IDX_INT, {3'b000, b[3:0]}, PMAX_4);
      end
      if (b[5]) begin
        kind = KIND_LIT_NAME;
        flags[0] = b[4];
        flags[1] = b[3];
        return open_int(PH_NAME_INT, {4'b0000, b[2:0]}, PMAX_3);
      end
      if (b[4]) begin
        kind = KIND_PB_IDX;
        return open_int(PH_IDX_INT, {3'b000, b[3:0]}, PMAX_4);
      end
      kind = KIND_PB_NREF;
      flags[0] = b[3];
      return open_int(PH_IDX_INT, {4'b0000, b[2:0]}, PMAX_3);
    endfunction

    function line_desc_t describe(logic [1:0] st);
      line_desc_t d;
      d = '0;
      d.status = st;
      d.kind = kind;
      d.nbytes = nbytes;
      if (st == ST_OK) begin
        d.never_idx = flags[0];
        if (kind != KIND_LIT_NAME) begin
          d.tbl_idx = idx;
        end else begin
          d.name_h = flags[1];
          d.name_len = nlen;
          d.name_off = noff;
        end
        if (kind == KIND_NREF_STATIC || kind == KIND_NREF_DYN || kind == KIND_LIT_NAME ||
            kind == KIND_PB_NREF) begin
          d.val_h = flags[2];
          d.val_len = vlen;
          d.val_off = voff;
        end
      end
      return d;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      event_t ev;
      if (ph == PH_DRAIN) begin
        if (last) ph = PH_FIRST;
        return;
      end
      if (ph == PH_FIRST) nbytes = '0;
      if (nbytes != '1) nbytes++;
      ev = EV_NONE;
      case (ph)
        PH_FIRST: ev = first_byte(b);
        PH_IDX_INT, PH_NAME_INT, PH_VAL_INT: ev = more_int(b);
        PH_NAME_SKP: begin
          left--;
          if (left == 0) ph = PH_VHDR;
        end
        PH_VHDR: begin
          flags[2] = b[7];
          ev = open_int(PH_VAL_INT, b[6:0], PMAX_7);
        end
        PH_VAL_SKP: begin
          left--;
          if (left == 0) ev = EV_DONE;
        end
        default: ph = PH_FIRST;
      endcase
      if (ev == EV_DONE) begin
        lines_due.push_back(describe(ST_OK));
        ph = PH_FIRST;
      end else if (ev == EV_ERR) begin
        lines_due.push_back(describe(ST_PROTO));
        ph = last ? PH_FIRST : PH_DRAIN;
      end else if (last) begin
        lines_due.push_back(describe(ST_TRUNC));
        ph = PH_FIRST;
      end
    endfunction

    function void show(string tag, line_desc_t d);
      $display("  %s: status=%0d kind=%0d n=%0d index=%0h", tag, d.status, d.kind,
               d.never_idx, d.tbl_idx);
      $display("    name h=%0d size=%0h start=%0h value h=%0d size=%0h start=%0h bytes=%0d",
               d.name_h, d.name_len, d.name_off, d.val_h, d.val_len, d.val_off, d.nbytes);
    endfunction

    function void match_line(line_desc_t got);
      line_desc_t want;
      if (lines_due.size() == 0) begin
        bad++;
        if (shown < 10) begin
          shown++;
          $display("line descriptor with nothing pending");
          show("got", got);
        end
        return;
      end
      want = lines_due.pop_front();
      if (got !== want) begin
        bad++;
        if (shown < 10) begin
          shown++;
          $display("line descriptor mismatch");
          show("expected", want);
          show("got", got);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        section_end;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [2:0]  line_kind;
  logic        n_bit;
  logic [61:0] table_index;
  logic        name_coded;
  logic [61:0] name_size;
  logic [63:0] name_start;
  logic        value_coded;
  logic [61:0] value_size;
  logic [63:0] value_start;
  logic [63:0] line_bytes;

  field_line_tracker tracker = new();
  logic [7:0]  line_q[$];
  int unsigned sent_bytes;
  int unsigned cycle_cnt;
  bit          calm;

  qpack_field_line_parser_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .section_end   (section_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .line_kind     (line_kind),
    .n_bit         (n_bit),
    .table_index   (table_index),
    .name_coded    (name_coded),
    .name_size     (name_size),
    .name_start    (name_start),
    .value_coded   (value_coded),
    .value_size    (value_size),
    .value_start   (value_start),
    .line_bytes    (line_bytes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [63:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 64'($urandom_range(0, 20));
    if (r < 70) return 64'($urandom_range(0, 600));
    if (r < 84) return 64'($urandom_range(0, 32'h00FF_FFFF));
    if (r < 92) return {$urandom, $urandom} >> $urandom_range(2, 40);
    if (r < 95) return WIDE_MAX - 64'($urandom_range(0, 3));
    // at or past the 62-bit limit
    return WIDE_MAX + 64'd1 + ({$urandom, $urandom} >> $urandom_range(1, 62));
  endfunction

  function automatic logic [63:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 64'd0;
    if (r < 85) return 64'($urandom_range(1, 12));
    if (r < 97) return 64'($urandom_range(13, 70));
    return pick_index();
  endfunction

  // prefixed integer; now and then padded with zero continuation chunks
  function automatic void put_int(logic [7:0] head, int pbits, logic [63:0] v);
    logic [63:0] pmax;
    logic [63:0] rest;
    int          pads;
    pmax = (64'd1 << pbits) - 1;
    if (v < pmax) begin
      line_q.push_back(head | v[7:0]);
      return;
    end
    line_q.push_back(head | pmax[7:0]);
    rest = v - pmax;
    while (rest >= 128) begin
      line_q.push_back({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    pads = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 10) : 0;
    if (pads == 0) begin
      line_q.push_back({1'b0, rest[6:0]});
    end else begin
      line_q.push_back({1'b1, rest[6:0]});
      repeat (pads - 1) line_q.push_back(8'h80);
      line_q.push_back(8'h00);
    end
  endfunction

  // string body; a huge length only gets a few bytes and is cut by section end
  function automatic void put_chars(logic [63:0] len);
    int unsigned n;
    n = (len > 80) ? $urandom_range(0, 8) : int'(len);
    repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_str();
    logic [63:0] len;
    len = pick_len();
    put_int({1'($urandom_range(0, 1)), 7'b0}, 7, len);
    put_chars(len);
  endfunction

  function automatic void add_line();
    logic [2:0]  k;
    logic        nb;
    logic        hb;
    logic [63:0] len;
    k = 3'($urandom_range(0, 6));
    nb = 1'($urandom_range(0, 1));
    hb = 1'($urandom_range(0, 1));
    case (k)
      KIND_IDX_STATIC, KIND_IDX_DYN: begin
        put_int({1'b1, k == KIND_IDX_STATIC, 6'b0}, 6, pick_index());
      end
      KIND_NREF_STATIC, KIND_NREF_DYN: begin
        put_int({2'b01, nb, k == KIND_NREF_STATIC, 4'b0}, 4, pick_index());
        put_str();
      end
      KIND_LIT_NAME: begin
        len = pick_len();
        put_int({3'b001, nb, hb, 3'b0}, 3, len);
        put_chars(len);
        put_str();
      end
      KIND_PB_IDX: begin
        put_int(8'h10, 4, pick_index());
      end
      default: begin
        put_int({4'b0000, nb, 3'b0}, 3, pick_index());
        put_str();
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      in_valid = 1'b0;
      data_byte = 8'($urandom_range(0, 255));
      section_end = 1'($urandom_range(0, 1));
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    section_end = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_section();
    foreach (line_q[i]) push_byte(line_q[i], i == line_q.size() - 1);
    sent_bytes += line_q.size();
  endtask

  task automatic random_section();
    int r;
    int cut;
    line_q.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) add_line();
      if (r < 22 && line_q.size() > 1) begin
        cut = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > cut) void'(line_q.pop_back());
      end
    end
    send_section();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tracker.match_line({status, line_kind, n_bit, table_index, name_coded,
                            name_size, name_start, value_coded, value_size, value_start,
                            line_bytes});
      end
      if (in_valid && !in_stall) tracker.take_byte(data_byte, section_end);
    end
  end

  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      out_stall = 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      n = gap_len();
      if (n != 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    section_end = 1'b0;
    sent_bytes = 0;
    calm = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // every kind at least once, empty strings, line ending on section end
    line_q = '{8'h00, 8'h80, 8'hC0, 8'hFF, 8'h7F, 8'h85, 8'h51, 8'h00, 8'h6F, 8'h02,
               8'h81, 8'hAA, 8'h3A, 8'h61, 8'h62, 8'h00, 8'h20, 8'h00, 8'h1F, 8'h00,
               8'h08, 8'h01, 8'h7A};
    send_section();
    // cut inside the value string
    line_q = '{8'h52, 8'h05, 8'h61};
    send_section();
    // index past 62 bits, failing on the last 0xFF byte and draining to section end
    line_q = '{8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'h7F};
    send_section();

    while (sent_bytes < 1800) begin
      if ($urandom_range(0, 4) == 0) calm = ~calm;
      random_section();
    end
    in_valid = 1'b0;

    while (tracker.lines_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.bad == 0 && tracker.lines_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/qfp_pkg.sv
src/qfp_int_step.sv
src/qpack_field_line_parser_core.sv
src/qfp_checker.sv
test/tb_qpack_field_line_parser_core.sv
